@@ design/bdlp_pkg.sv @@
// Shared types and constants for the button debounce / long-press unit.
// No dependencies; imported by every module of the block.
package bdlp_pkg;

  // Number of debounced buttons (lanes); legal range 1 to 16
  localparam int NUM_BUTTONS = 4;
  // Width of each per-button field on the stream ports
  localparam int FIELD_W     = 4;
  localparam int TICKS_W     = 16;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_ADDR_W  = 1;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 8;

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_PRESSED_LEVEL = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_LONG_TICKS    = 1'd1;

  localparam logic [TICKS_W-1:0] LONG_TICKS_RESET = 16'd500;

  // Debounce phases
  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_SEEN  = 3'd1,
    PH_DROP  = 3'd2,
    PH_QUAL  = 3'd3,
    PH_HELD  = 3'd4
  } phase_t;

  // Per-tick control into one lane
  typedef struct packed {
    logic step;
    logic raw;
    logic ack_press;
    logic ack_long;
  } lane_ctrl_t;

  // Flag values a lane will hold after the current tick
  typedef struct packed {
    logic press_flag;
    logic long_flag;
  } lane_flags_t;

  // Result of one tick as handed to the output stage
  typedef struct packed {
    logic [FIELD_W-1:0] long_flags;
    logic [FIELD_W-1:0] press_flags;
  } result_t;

endpackage

@@ design/bdlp_lane.sv @@
// One button lane: five-phase debouncer, hold countdown and sticky flags.
// Depends on bdlp_pkg.
module bdlp_lane
  import bdlp_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  lane_ctrl_t          ctrl,
  input  logic                pressed_level,
  input  logic [TICKS_W-1:0]  long_ticks,
  output lane_flags_t         flags_nxt
);

  phase_t               phase_r, phase_nxt;
  logic [TICKS_W-1:0]   count_r, count_nxt;
  logic                 press_r, press_nxt;
  logic                 long_r,  long_nxt;
  logic                 pressed;

  assign pressed = (ctrl.raw == pressed_level);

  // Next phase
  always_comb begin
    unique case (phase_r)
      PH_IDLE: phase_nxt = pressed ? PH_SEEN : PH_IDLE;
      PH_SEEN: phase_nxt = pressed ? PH_QUAL : PH_DROP;
      PH_DROP: phase_nxt = pressed ? PH_SEEN : PH_IDLE;
      PH_QUAL: phase_nxt = pressed ? PH_HELD : PH_SEEN;
      PH_HELD: phase_nxt = pressed ? PH_HELD : PH_SEEN;
      default: phase_nxt = PH_IDLE;
    endcase
  end

  // Countdown and flags; acknowledges apply before the scan
  always_comb begin
    count_nxt = count_r;
    press_nxt = press_r & ~ctrl.ack_press;
    long_nxt  = long_r & ~ctrl.ack_long;
    unique case (phase_r)
      PH_IDLE: press_nxt = 1'b0;
      PH_QUAL: begin
        if (pressed) begin
          press_nxt = 1'b1;
          count_nxt = long_ticks;
        end
      end
      PH_HELD: begin
        if (pressed && count_r != '0) begin
          count_nxt = count_r - 1'b1;
          if (count_r == TICKS_W'(1)) long_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign flags_nxt = '{press_flag: press_nxt, long_flag: long_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      count_r <= '0;
      press_r <= 1'b0;
      long_r  <= 1'b0;
    end else if (ctrl.step) begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      press_r <= press_nxt;
      long_r  <= long_nxt;
    end
  end

endmodule

@@ design/bdlp_out_stage.sv @@
// Output register with a one-entry skid buffer for the result stream.
// Depends on bdlp_pkg.
module bdlp_out_stage
  import bdlp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  result_t                push_data,
  output logic                   room,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  logic    out_vld_r, out_vld_nxt;
  logic    skid_vld_r, skid_vld_nxt;
  result_t out_data_r, out_data_nxt;
  result_t skid_data_r, skid_data_nxt;
  logic    pop;

  assign pop  = out_vld_r & out_tready;
  assign room = ~skid_vld_r;

  // Steering: skid drains first, new transaction fills the free slot
  always_comb begin
    out_vld_nxt   = out_vld_r & ~pop;
    skid_vld_nxt  = skid_vld_r;
    out_data_nxt  = out_data_r;
    skid_data_nxt = skid_data_r;
    if (pop && skid_vld_r) begin
      out_vld_nxt  = 1'b1;
      out_data_nxt = skid_data_r;
      skid_vld_nxt = 1'b0;
    end
    if (push) begin
      if (!out_vld_nxt) begin
        out_vld_nxt  = 1'b1;
        out_data_nxt = push_data;
      end else begin
        skid_vld_nxt  = 1'b1;
        skid_data_nxt = push_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = OUT_TDATA_W'(out_data_r);

endmodule

@@ design/button_debounce_long_press_unit.sv @@
// Button debouncer with long-press detection, top level.
// Depends on bdlp_pkg, bdlp_lane and bdlp_out_stage.
//
// Each input transaction is one scan tick carrying raw pin levels and
// acknowledge masks for press and long-press flags. Every button has its own
// lane (debouncer, 16-bit hold countdown, sticky flags); all lanes step
// together on an accepted transaction and their next flags are merged into
// one result transaction.
// Throughput: one tick per cycle while in_tready is high; all lanes update in
// the acceptance cycle, and the result is registered in the output stage.
// Stall: a one-entry skid buffer behind the output register keeps in_tready
// high through the first stalled cycle; in_tready drops only while both the
// output register and the skid entry are full.
// Reset (rst_n, synchronous, active low): all buttons idle, countdowns and
// flags zero, pressed level 0, long-press ticks 500, no result pending.
// Configuration: cfg_wr_en writes cfg_wdata into register cfg_addr
// (0 pressed level, 1 long-press ticks); write only while idle.
module button_debounce_long_press_unit
  import bdlp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [3:0] raw_levels, [7:4] ack_press_mask, [11:8] ack_long_mask, [15:12] zero
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [3:0] press_flags, [7:4] long_flags
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  logic                pressed_level_r;
  logic [TICKS_W-1:0]  long_ticks_r;
  logic                accept;
  logic [FIELD_W-1:0]  raw_levels, ack_press_mask, ack_long_mask;
  lane_flags_t         lane_flags [NUM_BUTTONS];
  result_t             result;

  assign raw_levels     = in_tdata[FIELD_W-1:0];
  assign ack_press_mask = in_tdata[2*FIELD_W-1:FIELD_W];
  assign ack_long_mask  = in_tdata[3*FIELD_W-1:2*FIELD_W];
  assign accept         = in_tvalid & in_tready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pressed_level_r <= 1'b0;
      long_ticks_r    <= LONG_TICKS_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        CFG_PRESSED_LEVEL: pressed_level_r <= cfg_wdata[0];
        CFG_LONG_TICKS:    long_ticks_r    <= cfg_wdata[TICKS_W-1:0];
        default: ;
      endcase
    end
  end

  // Lanes; buttons beyond the reported field see level 0 and no acknowledge
  for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_lane
    lane_ctrl_t ctrl;
    if (i < FIELD_W) begin : g_rep
      assign ctrl = '{step: accept, raw: raw_levels[i],
                      ack_press: ack_press_mask[i], ack_long: ack_long_mask[i]};
    end else begin : g_hid
      assign ctrl = '{step: accept, raw: 1'b0, ack_press: 1'b0, ack_long: 1'b0};
    end
    bdlp_lane u_lane (
      .clk           (clk),
      .rst_n         (rst_n),
      .ctrl          (ctrl),
      .pressed_level (pressed_level_r),
      .long_ticks    (long_ticks_r),
      .flags_nxt     (lane_flags[i])
    );
  end

  // Merge lane flags into the result word
  for (genvar i = 0; i < FIELD_W; i++) begin : g_merge
    if (i < NUM_BUTTONS) begin : g_on
      assign result.press_flags[i] = lane_flags[i].press_flag;
      assign result.long_flags[i]  = lane_flags[i].long_flag;
    end else begin : g_off
      assign result.press_flags[i] = 1'b0;
      assign result.long_flags[i]  = 1'b0;
    end
  end

  bdlp_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (accept),
    .push_data  (result),
    .room       (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

`ifndef SYNTHESIS
  // An accepted tick is always followed by out_tvalid high in the next cycle
  a_accept_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_tvalid)
    else $error("accepted tick produced no result");

  // Backpressure on the input only while a result is waiting
  a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with no pending result");

  // Nothing is presented right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_tvalid)
    else $error("result valid after reset");
`endif

endmodule
